[src/wrgs_pkg.sv]
`default_nettype none
package wrgs_pkg;

   typedef enum logic [2:0] {
      ACT_CLEAR = 3'd0,
      ACT_ADD   = 3'd1,
      ACT_SET   = 3'd2,
      ACT_STEP  = 3'd3,
      ACT_READ  = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      CSR_GAIN = 2'd0,
      CSR_COLS = 2'd1,
      CSR_ROWS = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_RDCELL,
      ST_WRCELL,
      ST_VFETCH,
      ST_VNBR,
      ST_VCALC,
      ST_VMUL,
      ST_VWRITE,
      ST_HREAD,
      ST_HWRITE,
      ST_RESULT
   } state_type;

   localparam int SIN45_Q16   = 46341;
   localparam int GAIN_RESET  = 2458;
   localparam int ONE_Q16     = 65536;

   // Saturate a 41 bit signed sum to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
      logic signed [40:0] hi;
      logic signed [40:0] lo;
      hi = 41'sd2147483647;
      lo = -41'sd2147483648;
      if (v > hi) return 32'sh7FFFFFFF;
      else if (v < lo) return 32'sh80000000;
      else return v[31:0];
   endfunction

endpackage
`default_nettype wire

[src/wrgs_mem.sv]
`default_nettype none
// Single port synchronous memory, registered read data
module wrgs_mem #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] addr,
   input  wire logic [31:0]   wr_data,
   output logic [31:0]        rd_data
);
   logic [31:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

[src/wave_ripple_grid_step.sv]
`default_nettype none
// From the accepting edge to rsp_tvalid: add/set/read of a cell in the grid pass RDCELL, WRCELL;
//   other actions and cells outside the grid go to RESULT; step runs VFETCH, VNBR, VCALC, VMUL,
//   VWRITE per cell (velocity pass), then HREAD, HWRITE per cell (height pass); clear sweeps 2^AW.
// Throughput: one command at a time; the next beat is taken once the result is taken.
// Reset: the grid is swept to zero (all 2^AW addresses, AW = clog2(MAX_COLS) + clog2(MAX_ROWS))
//   before the first beat is accepted; state, action, clear and config registers reset at once.
module wave_ripple_grid_step #(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // action[2:0], cell_col[10:3], cell_row[18:11], height_in[50:19], zero pad
   input  wire logic [55:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // height_out[31:0], brightness[39:32], in_grid[40], zero pad
   output logic [47:0]      rsp_tdata,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wr_data
);
   import wrgs_pkg::*;

   localparam int CW    = $clog2(MAX_COLS);
   localparam int RW    = $clog2(MAX_ROWS);
   localparam int AW    = CW + RW;
   localparam int DEPTH = 1 << AW;

   // configuration
   logic [15:0] gain_ff;
   logic [6:0]  cols_cfg_ff, rows_cfg_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff     <= 16'(GAIN_RESET);
         cols_cfg_ff <= 7'd64;
         rows_cfg_ff <= 7'd64;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_GAIN: gain_ff     <= csr_wr_data;
            CSR_COLS: cols_cfg_ff <= csr_wr_data[6:0];
            CSR_ROWS: rows_cfg_ff <= csr_wr_data[6:0];
            default: ;
         endcase
      end
   end

   // effective grid size, 11 bit to cover up to 1024
   logic [10:0] ncols, nrows;
   always_comb begin
      if (cols_cfg_ff == 7'd0) ncols = 11'd1;
      else if (11'(cols_cfg_ff) > 11'(MAX_COLS)) ncols = 11'(MAX_COLS);
      else ncols = 11'(cols_cfg_ff);
      if (rows_cfg_ff == 7'd0) nrows = 11'd1;
      else if (11'(rows_cfg_ff) > 11'(MAX_ROWS)) nrows = 11'(MAX_ROWS);
      else nrows = 11'(rows_cfg_ff);
   end

   // memories
   logic          h_we, v_we;
   logic [AW-1:0] h_addr, v_addr;
   logic [31:0]   h_wd, v_wd, h_rd, v_rd;
   wrgs_mem #(.DEPTH(DEPTH), .AW(AW)) u_hmem (
      .clock(clock), .wr_en(h_we), .addr(h_addr), .wr_data(h_wd), .rd_data(h_rd));
   wrgs_mem #(.DEPTH(DEPTH), .AW(AW)) u_vmem (
      .clock(clock), .wr_en(v_we), .addr(v_addr), .wr_data(v_wd), .rd_data(v_rd));

   state_type st_ff, st_in;

   // command registers
   logic [2:0]         act_ff;
   logic signed [31:0] val_ff;
   logic [AW-1:0]      idx_ff;
   logic [AW:0]        clr_ff;
   logic [10:0]        c_ff, r_ff;
   logic [3:0]         k_ff;            // neighbour counter 0..8
   logic signed [35:0] orth_ff, diag_ff;
   logic signed [31:0] hc_ff;           // centre height
   logic signed [52:0] acc_ff;
   logic signed [50:0] prod_ff;
   logic [31:0]        rsp_h_ff;
   logic [7:0]         rsp_b_ff;
   logic               rsp_g_ff;
   logic               clr_done;

   // request decode
   logic [2:0]        rq_act;
   logic signed [7:0] rq_col, rq_row;
   logic              rq_inside;
   assign rq_act    = req_tdata[2:0];
   assign rq_col    = req_tdata[10:3];
   assign rq_row    = req_tdata[18:11];
   assign rq_inside = !rq_col[7] && !rq_row[7]
                      && (11'(rq_col) < ncols) && (11'(rq_row) < nrows);

   assign req_tready = (st_ff == ST_IDLE) && clr_done;
   assign rsp_tvalid = (st_ff == ST_RESULT);
   assign rsp_tdata  = {7'd0, rsp_g_ff, rsp_b_ff, rsp_h_ff};
   assign clr_done   = clr_ff[AW];

   logic last_cell;
   assign last_cell = (c_ff == ncols - 11'd1) && (r_ff == nrows - 11'd1);

   // neighbour coordinate for counter k (0..7), clamped to border
   logic [10:0] nb_c, nb_r;
   logic signed [11:0] dc, dr;
   always_comb begin
      dc = 12'sd0; dr = 12'sd0;
      case (k_ff[2:0])
         3'd0: begin dc = -12'sd1; dr = -12'sd1; end
         3'd1: begin dc =  12'sd1; dr = -12'sd1; end
         3'd2: begin dc = -12'sd1; dr =  12'sd1; end
         3'd3: begin dc =  12'sd1; dr =  12'sd1; end
         3'd4: begin dc =  12'sd0; dr = -12'sd1; end
         3'd5: begin dc = -12'sd1; dr =  12'sd0; end
         3'd6: begin dc =  12'sd1; dr =  12'sd0; end
         default: begin dc = 12'sd0; dr = 12'sd1; end
      endcase
      if ($signed({1'b0, c_ff}) + dc < 0) nb_c = 11'd0;
      else if ($signed({1'b0, c_ff}) + dc > $signed({1'b0, ncols - 11'd1})) nb_c = ncols - 11'd1;
      else nb_c = 11'($signed({1'b0, c_ff}) + dc);
      if ($signed({1'b0, r_ff}) + dr < 0) nb_r = 11'd0;
      else if ($signed({1'b0, r_ff}) + dr > $signed({1'b0, nrows - 11'd1})) nb_r = nrows - 11'd1;
      else nb_r = 11'($signed({1'b0, r_ff}) + dr);
   end

   logic [AW-1:0] cell_addr, nb_addr;
   assign cell_addr = {r_ff[RW-1:0], c_ff[CW-1:0]};
   assign nb_addr   = {nb_r[RW-1:0], nb_c[CW-1:0]};

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE:   if (!clr_done) st_in = ST_CLEAR;
                    else if (req_tvalid) begin
                       unique case (rq_act)
                          ACT_CLEAR: st_in = ST_CLEAR;
                          ACT_STEP:  st_in = ST_VFETCH;
                          ACT_ADD, ACT_SET, ACT_READ:
                             st_in = rq_inside ? ST_RDCELL : ST_RESULT;
                          default:   st_in = ST_RESULT;
                       endcase
                    end
         ST_CLEAR:  if (clr_ff[AW-1:0] == AW'(DEPTH - 1))
                       st_in = (act_ff == ACT_CLEAR) ? ST_RESULT : ST_IDLE;
         ST_RDCELL: st_in = ST_WRCELL;
         ST_WRCELL: st_in = ST_RESULT;
         ST_VFETCH: st_in = ST_VNBR;
         ST_VNBR:   if (k_ff == 4'd8) st_in = ST_VCALC;
         ST_VCALC:  st_in = ST_VMUL;
         ST_VMUL:   st_in = ST_VWRITE;
         ST_VWRITE: st_in = last_cell ? ST_HREAD : ST_VFETCH;
         ST_HREAD:  st_in = ST_HWRITE;
         ST_HWRITE: st_in = last_cell ? ST_RESULT : ST_HREAD;
         ST_RESULT: if (rsp_tready) st_in = ST_IDLE;
         default:   st_in = ST_IDLE;
      endcase
   end

   // memory control
   logic signed [33:0] hsum;
   logic signed [33:0] vsum;
   logic signed [39:0] dv;
   always_comb begin
      h_we = 1'b0; v_we = 1'b0;
      h_addr = cell_addr; v_addr = cell_addr;
      h_wd = 32'd0; v_wd = 32'd0;
      hsum = 34'(signed'(h_rd)) + 34'(signed'(val_ff));
      vsum = 34'(signed'(h_rd)) + 34'(signed'(v_rd));
      dv   = 40'(prod_ff >>> 12);
      unique case (st_ff)
         ST_CLEAR: begin
            h_we = 1'b1; v_we = 1'b1;
            h_addr = clr_ff[AW-1:0]; v_addr = clr_ff[AW-1:0];
         end
         ST_IDLE:   h_addr = {RW'(rq_row[6:0]), CW'(rq_col[6:0])};
         ST_RDCELL: h_addr = idx_ff;
         ST_WRCELL: begin
            h_addr = idx_ff;
            if (act_ff == ACT_ADD) begin h_we = 1'b1; h_wd = sat32(41'(hsum)); end
            else if (act_ff == ACT_SET) begin h_we = 1'b1; h_wd = val_ff; end
         end
         ST_VNBR:   h_addr = nb_addr;
         ST_VWRITE: begin
            v_we = 1'b1;
            v_wd = sat32(41'(signed'(v_rd)) + 41'(dv));
         end
         ST_HWRITE: begin h_we = 1'b1; h_wd = sat32(41'(vsum)); end
         default: ;
      endcase
   end

   // brightness of the read height
   logic signed [31:0] clamp_h;
   logic [17:0]        bsum;
   logic [26:0]        bprod;
   always_comb begin
      if ($signed(h_rd) > 32'sd65536) clamp_h = 32'sd65536;
      else if ($signed(h_rd) < -32'sd65536) clamp_h = -32'sd65536;
      else clamp_h = h_rd;
      bsum  = 18'(clamp_h + 32'sd65536);
      bprod = 27'(bsum) * 27'd255 + 27'd65536;
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_IDLE;
         clr_ff <= '0;
         act_ff <= ACT_READ;
      end else begin
         st_ff <= st_in;
         if (st_ff == ST_CLEAR) begin
            if (clr_ff[AW-1:0] == AW'(DEPTH - 1)) clr_ff <= {1'b1, AW'(0)};
            else clr_ff <= clr_ff + 1'b1;
         end
         if (st_ff == ST_IDLE && clr_done && req_tvalid) begin
            act_ff <= rq_act;
            if (rq_act == ACT_CLEAR) clr_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (st_ff)
         ST_IDLE: if (req_tvalid) begin
            val_ff    <= req_tdata[50:19];
            idx_ff    <= h_addr;
            c_ff <= '0; r_ff <= '0;
            rsp_h_ff <= '0; rsp_b_ff <= '0; rsp_g_ff <= rq_inside;
         end
         ST_RDCELL: ;
         ST_WRCELL: if (act_ff == ACT_READ) begin
            rsp_h_ff <= h_rd;
            rsp_b_ff <= bprod[24:17];
         end
         ST_VFETCH: begin
            k_ff <= '0;
            orth_ff <= '0; diag_ff <= '0;
         end
         ST_VNBR: begin
            if (k_ff == 4'd0) hc_ff <= h_rd;  // centre read issued in VFETCH
            if (k_ff != 4'd0) begin
               if (k_ff <= 4'd4) diag_ff <= diag_ff + 36'(signed'(h_rd));
               else orth_ff <= orth_ff + 36'(signed'(h_rd));
            end
            k_ff <= k_ff + 4'd1;
         end
         ST_VCALC: begin
            acc_ff <= (53'(orth_ff) <<< 16)
                      + 53'(diag_ff) * 53'(SIN45_Q16) + 53'sd262144;
         end
         // product of offset and gain, rounded, registered in VMUL ahead of the velocity write
         ST_VMUL: begin
            prod_ff <= 51'(34'(acc_ff >>> 19) - 34'(hc_ff)) * 51'(gain_ff) + 51'sd2048;
         end
         ST_VWRITE: begin
            if (last_cell) begin c_ff <= '0; r_ff <= '0; end
            else if (c_ff == ncols - 11'd1) begin c_ff <= '0; r_ff <= r_ff + 11'd1; end
            else c_ff <= c_ff + 11'd1;
         end
         ST_HWRITE: begin
            if (c_ff == ncols - 11'd1) begin c_ff <= '0; r_ff <= r_ff + 11'd1; end
            else c_ff <= c_ff + 11'd1;
         end
         default: ;
      endcase
   end

   logic unused_ok;
   assign unused_ok = ^{req_tdata[55:51]};
endmodule
`default_nettype wire

[dv/tb_wave_ripple_grid_step.sv]
`timescale 1ns / 1ps
`default_nettype none
module tb_wave_ripple_grid_step;
   import wrgs_pkg::*;

   localparam int NCOLS = 64;
   localparam int NROWS = 64;
   localparam int NCELL = NCOLS * NROWS;
   localparam int IDLE_LIMIT = 400000;
   localparam int LONG_HOLD = 300;
   localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
   localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;
   localparam int Q_ONE = 32'h0001_0000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [15:0] csr_wr_data;

   wave_ripple_grid_step #(.MAX_COLS(NCOLS), .MAX_ROWS(NROWS)) i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   typedef struct packed {
      logic [31:0] height;
      logic [7:0]  bright;
      logic        in_grid;
   } cell_view_type;

   typedef struct {
      logic [2:0]        act;
      logic signed [7:0] col;
      logic signed [7:0] row;
      logic [31:0]       val;
      bit                typed;
      cell_view_type     want;
   } dir_row_type;

   // grid model
   int          grid_h [NCELL];
   int          grid_v [NCELL];
   logic [15:0] gain;
   logic [6:0]  cols_reg;
   logic [6:0]  rows_reg;

   cell_view_type views_due [$];
   int          errors;
   bit          quiet;
   bit          long_hold;

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int sat32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return int'(v);
   endfunction

   // nearest, ties upward
   function automatic longint round_sh(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic int cols_in_use();
      if (cols_reg == 0) return 1;
      return (cols_reg > NCOLS) ? NCOLS : int'(cols_reg);
   endfunction

   function automatic int rows_in_use();
      if (rows_reg == 0) return 1;
      return (rows_reg > NROWS) ? NROWS : int'(rows_reg);
   endfunction

   function automatic longint h_clamped(int c, int r, int nc, int nr);
      if (c < 0) c = 0;
      if (c > nc - 1) c = nc - 1;
      if (r < 0) r = 0;
      if (r > nr - 1) r = nr - 1;
      return longint'(grid_h[r * NCOLS + c]);
   endfunction

   // one ripple update: velocities from old heights, then heights
   task automatic ripple();
      int nc;
      int nr;
      int i;
      longint dg;
      longint ot;
      longint avg;
      nc = cols_in_use();
      nr = rows_in_use();
      for (int r = 0; r < nr; r++) begin
         for (int c = 0; c < nc; c++) begin
            i = r * NCOLS + c;
            dg = h_clamped(c-1, r-1, nc, nr) + h_clamped(c+1, r-1, nc, nr)
               + h_clamped(c-1, r+1, nc, nr) + h_clamped(c+1, r+1, nc, nr);
            ot = h_clamped(c, r-1, nc, nr) + h_clamped(c-1, r, nc, nr)
               + h_clamped(c+1, r, nc, nr) + h_clamped(c, r+1, nc, nr);
            avg = round_sh(ot * Q_ONE + dg * SIN45_Q16, 19);
            grid_v[i] = sat32(longint'(grid_v[i])
                        + round_sh((avg - longint'(grid_h[i])) * longint'(gain), 12));
         end
      end
      for (int r = 0; r < nr; r++)
         for (int c = 0; c < nc; c++) begin
            i = r * NCOLS + c;
            grid_h[i] = sat32(longint'(grid_h[i]) + longint'(grid_v[i]));
         end
   endtask

   task automatic apply_command(input logic [2:0] act, input logic signed [7:0] col,
                                input logic signed [7:0] row, input logic [31:0] val,
                                output cell_view_type v);
      bit in_range;
      int idx;
      longint h;
      longint cl;
      in_range = col >= 0 && int'(col) < cols_in_use()
                 && row >= 0 && int'(row) < rows_in_use();
      idx = in_range ? int'(row) * NCOLS + int'(col) : 0;
      v = '0;
      v.in_grid = in_range;
      case (act)
         ACT_CLEAR: begin
            foreach (grid_h[k]) begin
               grid_h[k] = 0;
               grid_v[k] = 0;
            end
         end
         ACT_ADD: if (in_range)
            grid_h[idx] = sat32(longint'(grid_h[idx]) + longint'($signed(val)));
         ACT_SET: if (in_range) grid_h[idx] = $signed(val);
         ACT_STEP: ripple();
         ACT_READ: begin
            if (in_range) begin
               h = grid_h[idx];
               cl = (h > Q_ONE) ? Q_ONE : ((h < -Q_ONE) ? -Q_ONE : h);
               v.height = grid_h[idx];
               v.bright = 8'(((cl + Q_ONE) * 255 + 65536) >>> 17);
            end
         end
         default: ;
      endcase
   endtask

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      errors++;
      $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
   endtask

   // result checker
   always @(posedge clock) begin
      cell_view_type got;
      cell_view_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.height = rsp_tdata[31:0];
         got.bright = rsp_tdata[39:32];
         got.in_grid = rsp_tdata[40];
         if (views_due.size() == 0) begin
            report("unexpected beat", rsp_tdata, 0);
         end else begin
            w = views_due.pop_front();
            if (got.height !== w.height) report("height_out", got.height, w.height);
            if (got.bright !== w.bright) report("brightness", got.bright, w.bright);
            if (got.in_grid !== w.in_grid) report("in_grid", got.in_grid, w.in_grid);
         end
      end
   end

   // watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      int still;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) still = 0;
      else still++;
      if (still >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // receiver: random stalls, one long hold on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD - 1) @(posedge clock);
            long_hold = 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 3)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // one register write; the caller drops csr_wr_en after the last one
   task automatic reg_write(input csr_index_type idx, input logic [15:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      case (idx)
         CSR_GAIN: gain = data;
         CSR_COLS: cols_reg = data[6:0];
         CSR_ROWS: rows_reg = data[6:0];
         default: ;
      endcase
   endtask

   // offer one command, wait until it is accepted, queue the expected view
   task automatic send_command(input logic [2:0] act, input logic signed [7:0] col,
                               input logic signed [7:0] row, input logic [31:0] val,
                               input bit typed, input cell_view_type want);
      cell_view_type v;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'd0, val, row, col, act};
      do @(posedge clock); while (!req_tready);
      apply_command(act, col, row, val, v);
      views_due.insert(views_due.size(), typed ? want : v);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (views_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // random command within or just past the current grid, now and then anywhere
   task automatic random_command(input bit allow_step);
      logic [2:0] act;
      logic signed [7:0] col;
      logic signed [7:0] row;
      logic [31:0] val;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 35) act = ACT_READ;
      else if (pick < 57) act = ACT_SET;
      else if (pick < 77) act = ACT_ADD;
      else if (pick < 90) act = allow_step ? ACT_STEP : ACT_READ;
      else if (pick < 94) act = ACT_CLEAR;
      else act = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
      col = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, cols_in_use()));
      row = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, rows_in_use()));
      case ($urandom_range(0, 3))
         0: val = $urandom;
         1: val = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: val = 32'($signed($urandom_range(0, 6 * Q_ONE)) - 3 * Q_ONE);
      endcase
      send_command(act, col, row, val, 1'b0, '0);
   endtask

   dir_row_type dir_tab [0:20] = '{
      '{ACT_READ,   8'sd0,    8'sd0,    32'h0,         1, '{32'h0, 8'd128, 1'b1}},
      '{ACT_READ,   -8'sd1,   8'sd0,    32'h0,         1, '{32'h0, 8'd0,   1'b0}},
      '{ACT_READ,   8'sd64,   8'sd0,    32'h0,         1, '{32'h0, 8'd0,   1'b0}},
      '{ACT_SET,    8'sd63,   8'sd63,   32'h7FFF_FFFF, 1, '{32'h0, 8'd0,   1'b1}},
      '{ACT_ADD,    8'sd63,   8'sd63,   32'h7FFF_FFFF, 1, '{32'h0, 8'd0,   1'b1}},
      '{ACT_READ,   8'sd63,   8'sd63,   32'h0,         1, '{32'h7FFF_FFFF, 8'd255, 1'b1}},
      '{ACT_SET,    8'sd0,    8'sd0,    32'h8000_0000, 1, '{32'h0, 8'd0,   1'b1}},
      '{ACT_ADD,    8'sd0,    8'sd0,    32'hFFFF_FFFF, 1, '{32'h0, 8'd0,   1'b1}},
      '{ACT_READ,   8'sd0,    8'sd0,    32'h0,         1, '{32'h8000_0000, 8'd0, 1'b1}},
      '{ACT_SET,    8'sd127,  -8'sd128, 32'h1234_5678, 1, '{32'h0, 8'd0,   1'b0}},
      '{ACT_SET,    -8'sd128, 8'sd127,  32'hFFFF_0000, 1, '{32'h0, 8'd0,   1'b0}},
      '{ACT_READ,   8'sd127,  8'sd127,  32'h0,         1, '{32'h0, 8'd0,   1'b0}},
      '{ACT_SPARE_FIRST, 8'sd0, 8'sd0,  32'hFFFF_FFFF, 1, '{32'h0, 8'd0,   1'b1}},
      '{ACT_SPARE_LAST,  8'sd5, 8'sd5,  32'h5555_AAAA, 1, '{32'h0, 8'd0,   1'b1}},
      '{ACT_SET,    8'sd10,   8'sd10,   32'h0001_0000, 0, '{32'h0, 8'd0,   1'b0}},
      '{ACT_STEP,   8'sd0,    8'sd0,    32'h0,         0, '{32'h0, 8'd0,   1'b0}},
      '{ACT_READ,   8'sd10,   8'sd10,   32'h0,         0, '{32'h0, 8'd0,   1'b0}},
      '{ACT_READ,   8'sd11,   8'sd11,   32'h0,         0, '{32'h0, 8'd0,   1'b0}},
      '{ACT_READ,   8'sd63,   8'sd0,    32'h0,         0, '{32'h0, 8'd0,   1'b0}},
      '{ACT_CLEAR,  8'sd0,    8'sd0,    32'h0,         1, '{32'h0, 8'd0,   1'b1}},
      '{ACT_READ,   8'sd63,   8'sd63,   32'h0,         1, '{32'h0, 8'd128, 1'b1}}
   };

   // stimulus
   initial begin
      logic [15:0] ph_gain [7];
      logic [15:0] ph_cols [7];
      logic [15:0] ph_rows [7];
      bit stepped;
      ph_gain = '{16'd0, 16'hFFFF, 16'd4096, 16'd1000, 16'd2458, 16'd300, 16'd6000};
      ph_cols = '{16'd1, 16'd2, 16'd5, 16'd0, 16'd127, 16'd8, 16'd64};
      ph_rows = '{16'd1, 16'd3, 16'd4, 16'd0, 16'd1, 16'd8, 16'd64};
      errors = 0;
      quiet = 1'b0;
      long_hold = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_wr_en = 1'b0;
      csr_index = CSR_GAIN;
      csr_wr_data = '0;
      foreach (grid_h[k]) begin
         grid_h[k] = 0;
         grid_v[k] = 0;
      end
      gain = GAIN_RESET;
      cols_reg = 7'd64;
      rows_reg = 7'd64;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[k])
         send_command(dir_tab[k].act, dir_tab[k].col, dir_tab[k].row, dir_tab[k].val,
                      dir_tab[k].typed, dir_tab[k].want);
      drain();

      for (int p = 0; p < 7; p++) begin
         reg_write(CSR_GAIN, ph_gain[p]);
         reg_write(CSR_COLS, ph_cols[p]);
         reg_write(CSR_ROWS, ph_rows[p]);
         csr_wr_en <= 1'b0;
         quiet = (p == 6);
         if (p == 2) long_hold = 1'b1;
         stepped = 1'b0;
         for (int n = 0; n < 14; n++) begin
            // a lone pause with everything delivered
            if (p == 4 && n == 7) drain();
            random_command(cols_in_use() * rows_in_use() <= 64 || !stepped);
            if (cols_in_use() * rows_in_use() > 64 &&
                $signed(req_tdata[2:0]) == $signed(ACT_STEP)) stepped = 1'b1;
         end
         drain();
      end

      if (errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
`default_nettype wire

[files.f]
src/wrgs_pkg.sv
src/wrgs_mem.sv
src/wave_ripple_grid_step.sv
dv/tb_wave_ripple_grid_step.sv
